FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define A_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define A_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define A_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define A_HOLDS(lbl, clk, rst_n, expr)
`define A_IMPLIES(lbl, clk, rst_n, ante, cons)
`define A_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants for the byte double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] push_value;
    } t_req;

    typedef struct packed {
        logic [7:0] pop_value;
        t_status    status;
        logic [4:0] occupancy;
    } t_res;

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic             ins_head;
        logic             ins_tail;
        logic             rem_head;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] last;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: sv/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One byte of queue storage; shifts to either neighbour or loads at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell (
    input  wire logic                        i_clk,
    input  wire logic [bdq_pkg::IDX_W-1:0]   i_idx,
    input  wire bdq_pkg::t_cell_ctl          i_ctl,
    input  wire logic [7:0]                  i_left,
    input  wire logic [7:0]                  i_right,
    input  wire logic [7:0]                  i_push_value,
    output logic      [7:0]                  o_data,
    output logic                             o_last
);
    import bdq_pkg::*;

    logic [7:0] r_data;
    logic [7:0] n_data;
    logic       w_tail;

    assign w_tail = (CNT_W'(i_idx) == i_ctl.count);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins_head) begin
            n_data = i_left;
        end else if (i_ctl.rem_head) begin
            n_data = i_right;
        end else if (i_ctl.ins_tail && w_tail) begin
            n_data = i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_last = (CNT_W'(i_idx) == i_ctl.last);

endmodule

`default_nettype wire

FILE: sv/byte_double_ended_queue.sv
// ----------------------------------------------------------------------------
// byte_double_ended_queue
// Bounded double-ended byte queue built as a row of shifting storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low;
//   i_req carries the command and the byte to push. Exactly one result per
//   transaction appears on o_res the following cycle, marked by o_valid for
//   one cycle. A new transaction may be issued every cycle while busy is low;
//   the row of cells updates in the same edge that registers the result, so
//   nothing waits.
//   Cell 0 always holds the front byte. A front push shifts the row one
//   place towards the back, a front pop shifts it one place towards the
//   front, a back push loads the cell at the current fill level and a back
//   pop reads the last occupied cell. Errors (pop when empty, push when
//   full) leave the contents untouched.
//   Synchronous reset empties the queue; busy is high while reset is held.
//   Results cannot be stalled: the receiver must take o_res when o_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_double_ended_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire bdq_pkg::t_req i_req,
    output logic               o_valid,
    output bdq_pkg::t_res      o_res
);
    import bdq_pkg::*;

    `include "assert_macros.svh"

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_res             r_res;
    t_res             n_res;
    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic [7:0]       w_back_byte;
    logic [7:0]       w_data [DEPTH];
    logic             w_last [DEPTH];

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [7:0] w_left;
        logic [7:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = i_req.push_value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = 8'h00;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_idx        (IDX_W'(g)),
            .i_ctl        (w_ctl),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_push_value (i_req.push_value),
            .o_data       (w_data[g]),
            .o_last       (w_last[g])
        );
    end

    always_comb begin
        w_back_byte = 8'h00;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_byte = w_back_byte | (w_last[k] ? w_data[k] : 8'h00);
        end
    end

    always_comb begin
        w_ctl            = '0;
        w_ctl.count      = r_count;
        w_ctl.last       = r_count - CNT_W'(1);
        n_count          = r_count;
        n_res.pop_value  = 8'h00;
        n_res.status     = ST_OK;
        if (w_accept) begin
            case (i_req.cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (w_full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_ctl.ins_head = (i_req.cmd == CMD_PUSH_FRONT);
                        w_ctl.ins_tail = (i_req.cmd == CMD_PUSH_BACK);
                        n_count        = r_count + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (w_empty) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        w_ctl.rem_head  = 1'b1;
                        n_res.pop_value = w_data[0];
                        n_count         = r_count - CNT_W'(1);
                    end
                end
                CMD_POP_BACK: begin
                    if (w_empty) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_res.pop_value = w_back_byte;
                        n_count         = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_res.status = ST_OK;
                end
            endcase
        end
        n_res.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `A_HOLDS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `A_IMPLIES(a_occ_tracks, i_clk, i_rst_n, o_valid, o_res.occupancy == 5'(r_count))
    `A_NEXT(a_idle_count, i_clk, i_rst_n, !w_accept, r_count == $past(r_count))
    `A_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, o_valid)
    `A_IMPLIES(a_error_no_value, i_clk, i_rst_n, o_valid && o_res.status != ST_OK,
               o_res.pop_value == 8'h00)

endmodule

`default_nettype wire

FILE: dv/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// Watches the command and result channels of the byte double-ended queue,
// keeps its own ring-buffer copy of the queue, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bdq_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_busy,
    input  wire bdq_pkg::t_req i_req,
    input  wire logic          i_valid,
    input  wire bdq_pkg::t_res i_res,
    output int                 o_fails,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_empty_pops,
    output int                 o_full_pushes
);
    import bdq_pkg::*;

    logic [7:0] bytes_held [DEPTH];
    int         head;
    int         fill;
    t_res       due_results [$];
    int         fails;
    int         results;
    int         empty_pops;
    int         full_pushes;

    initial begin
        fails         = 0;
        results       = 0;
        empty_pops    = 0;
        full_pushes   = 0;
        head          = 0;
        fill          = 0;
    end

    function automatic t_res deque_step(input t_req r);
        t_res res;
        int   pos;
        res.pop_value = 8'h00;
        res.status    = ST_OK;
        case (r.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (r.cmd == CMD_PUSH_FRONT) begin
                    head = (head + DEPTH - 1) % DEPTH;
                    bytes_held[head] = r.push_value;
                    fill++;
                end else begin
                    pos = (head + fill) % DEPTH;
                    bytes_held[pos] = r.push_value;
                    fill++;
                end
            end
            default: begin
                if (fill == 0) begin
                    res.status = ST_EMPTY;
                end else if (r.cmd == CMD_POP_FRONT) begin
                    res.pop_value = bytes_held[head];
                    head = (head + 1) % DEPTH;
                    fill--;
                end else begin
                    pos = (head + fill - 1) % DEPTH;
                    res.pop_value = bytes_held[pos];
                    fill--;
                end
            end
        endcase
        res.occupancy = 5'(fill);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            due_results.delete();
        end else begin
            if (i_valid) begin
                if (due_results.size() == 0) begin
                    if (fails < 10)
                        $display("mismatch: result with no transaction outstanding");
                    fails++;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    results++;
                    if (want.status == ST_EMPTY)
                        empty_pops++;
                    if (want.status == ST_FULL)
                        full_pushes++;
                    if (i_res.pop_value !== want.pop_value ||
                        i_res.status !== want.status ||
                        i_res.occupancy !== want.occupancy) begin
                        if (fails < 10)
                            $display({"mismatch at result %0d: expected value %02h ",
                                      "status %0d occupancy %0d, got value %02h ",
                                      "status %0d occupancy %0d"},
                                     results, want.pop_value, want.status,
                                     want.occupancy, i_res.pop_value, i_res.status,
                                     i_res.occupancy);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy)
                due_results.insert(due_results.size(), deque_step(i_req));
        end
        o_fails       <= fails;
        o_pending     <= due_results.size();
        o_results     <= results;
        o_empty_pops  <= empty_pops;
        o_full_pushes <= full_pushes;
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the byte double-ended queue with a directed opening (empty and full
// errors, extreme bytes, every command) then random runs biased towards
// filling, draining or balance, with random idle cycles on the command side.
// ----------------------------------------------------------------------------
module testbench;
    import bdq_pkg::*;

    localparam int N_ITEMS   = 1700;
    localparam int WDOG_MAX  = 1000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req req     = '0;
    logic o_valid;
    t_res o_res;

    int   fails;
    int   pending;
    int   results;
    int   empty_pops;
    int   full_pushes;
    int   issued   = 0;
    bit   gaps_on  = 1'b1;
    int   wdog     = 0;

    always #10 i_clk = ~i_clk;

    byte_double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    bdq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (req),
        .i_valid       (o_valid),
        .i_res         (o_res),
        .o_fails       (fails),
        .o_pending     (pending),
        .o_results     (results),
        .o_empty_pops  (empty_pops),
        .o_full_pushes (full_pushes)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    task automatic issue(input t_cmd c, input logic [7:0] v);
        gaps_on = !(issued >= 700 && issued < 1000);
        while (gaps_on && $urandom_range(99) < 27) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        req.cmd        <= c;
        req.push_value <= v;
        do @(posedge i_clk); while (busy);
        issued++;
    endtask

    task automatic random_op(input int push_pct);
        if ($urandom_range(99) < push_pct)
            issue($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, 8'($urandom));
        else
            issue($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, 8'($urandom));
    endtask

    initial begin
        int push_pct;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both pops on an empty queue, extreme bytes at both ends
        issue(CMD_POP_FRONT, 8'($urandom));
        issue(CMD_POP_BACK, 8'($urandom));
        issue(CMD_PUSH_FRONT, 8'h00);
        issue(CMD_PUSH_BACK, 8'hFF);
        issue(CMD_PUSH_FRONT, 8'hAA);
        issue(CMD_PUSH_BACK, 8'h55);
        issue(CMD_POP_FRONT, 8'($urandom));
        issue(CMD_POP_BACK, 8'($urandom));
        // fill to the brim from both ends, then push into a full queue
        for (int i = 0; i < 14; i++)
            issue(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, 8'($urandom));
        issue(CMD_PUSH_FRONT, 8'($urandom));
        issue(CMD_PUSH_BACK, 8'($urandom));

        while (issued < N_ITEMS) begin
            case ($urandom_range(7))
                0:       push_pct = 0;
                1, 2:    push_pct = 25;
                3, 4:    push_pct = 50;
                5, 6:    push_pct = 75;
                default: push_pct = 100;
            endcase
            repeat ($urandom_range(4, 40))
                random_op(push_pct);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d transactions, %0d of them pops on an empty queue",
                 results, empty_pops);
        $display("and %0d pushes on a full queue, with a stretch free of idle cycles",
                 full_pushes);
        if (fails == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
